// ===== rtl/tdp_pkg.sv =====
// ----------------------------------------------------------------------------
// Trial-division primality package
// Shared control and status types between the sequencer and the remainder
// unit.
// ----------------------------------------------------------------------------
package tdp_pkg;

    // Request from the sequencer to the remainder unit.
    typedef struct packed {
        logic start;
    } rem_ctl_t;

    // Status from the remainder unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } rem_sts_t;

endpackage

// ===== rtl/tdp_rem.sv =====
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Restoring division of a dividend by a divisor, one dividend bit per cycle
// through one shared subtractor. Reports whether the remainder is zero.
// ----------------------------------------------------------------------------
module tdp_rem
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int DIV_WIDTH   = 17
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rem_ctl_t               ctl,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [DIV_WIDTH-1:0]   divisor,
    output rem_sts_t               sts
);

    localparam int CntW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [DIV_WIDTH-1:0]   rem_reg, rem_next;
    logic [CntW-1:0]        cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_WIDTH:0]     shifted;
    logic [DIV_WIDTH:0]     trial;

    // One restoring step: bring in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, shift_reg[VALUE_WIDTH-1]};
    assign trial   = shifted - {1'b0, divisor};

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (ctl.start && !busy_reg) begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = CntW'(VALUE_WIDTH);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            if (trial[DIV_WIDTH]) begin
                rem_next = shifted[DIV_WIDTH-1:0];
            end else begin
                rem_next = trial[DIV_WIDTH-1:0];
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.zero = (rem_reg == '0);

    // The step counter is only nonzero while a division runs.
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> cnt_reg == '0)
        else $error("remainder counter active while idle");

    // A finished division is reported for exactly one cycle.
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

    // Completion follows the last busy cycle.
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("done without a running division");

endmodule

// ===== rtl/trial_division_primality.sv =====
// Magnitudes below 4 and even ones are settled without a division.
// Odd magnitudes m run one bit-serial remainder division, one dividend bit per cycle,
// for each odd trial divisor 3, 5 and so on up to sqrt(m), stopping at one that divides
// m; at most about 2^(VALUE_WIDTH/2-1) trial divisors.
// One item at a time; the input is ready again in the cycle after the previous result
// enters the output register.
// Reset (aresetn, synchronous, active low) clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// Trial-division primality test
// Reports whether the magnitude of a signed integer is prime, trying odd
// divisors under a small sequencer that shares one remainder unit.
// ----------------------------------------------------------------------------
module trial_division_primality
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // value
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata   // is_prime, zero padding
);

    localparam int DivW = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SqW  = VALUE_WIDTH + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOOP,
        ST_WAIT,
        ST_RESULT
    } state_t;

    state_t                 state_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [DivW-1:0]        div_reg;
    logic [SqW-1:0]         sq_reg;
    logic                   prime_reg;
    logic                   m_tvalid_reg;
    logic                   m_tdata_reg;
    logic                   start_reg;
    logic [VALUE_WIDTH-1:0] value_in;
    logic [VALUE_WIDTH-1:0] mag_in;
    logic [SqW-1:0]         sq_step;
    logic                   sq_over;
    rem_ctl_t               rem_ctl;
    rem_sts_t               rem_sts;

    // Magnitude of the incoming value; the most negative value maps onto itself.
    assign value_in = s_tdata[VALUE_WIDTH-1:0];
    assign mag_in   = value_in[VALUE_WIDTH-1] ? (~value_in + 1'b1) : value_in;

    // Next square: (d+2)^2 = d^2 + 4d + 4.
    assign sq_step = sq_reg + SqW'({div_reg, 2'b00}) + SqW'(4);
    assign sq_over = sq_reg > {1'b0, mag_reg};

    assign s_tready      = (state_reg == ST_IDLE);
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = {7'b0, m_tdata_reg};
    assign rem_ctl.start = start_reg;

    // Sequencer with the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            start_reg    <= 1'b0;
        end else begin
            // Pulse the remainder unit once for each trial divisor.
            start_reg <= (state_reg == ST_LOOP) && !sq_over;
            // The output register loads a result or empties on a transfer.
            if (state_reg == ST_RESULT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        mag_reg   <= mag_in;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    div_reg <= DivW'(3);
                    sq_reg  <= SqW'(9);
                    if (mag_reg < VALUE_WIDTH'(2)) begin
                        prime_reg <= 1'b0;
                        state_reg <= ST_RESULT;
                    end else if (mag_reg < VALUE_WIDTH'(4)) begin
                        prime_reg <= 1'b1;
                        state_reg <= ST_RESULT;
                    end else if (!mag_reg[0]) begin
                        prime_reg <= 1'b0;
                        state_reg <= ST_RESULT;
                    end else begin
                        state_reg <= ST_LOOP;
                    end
                end
                ST_LOOP: begin
                    if (sq_over) begin
                        prime_reg <= 1'b1;
                        state_reg <= ST_RESULT;
                    end else begin
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (rem_sts.done) begin
                        if (rem_sts.zero) begin
                            prime_reg <= 1'b0;
                            state_reg <= ST_RESULT;
                        end else begin
                            div_reg   <= div_reg + DivW'(2);
                            sq_reg    <= sq_step;
                            state_reg <= ST_LOOP;
                        end
                    end
                end
                ST_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg <= prime_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    tdp_rem #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH   (DivW)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (rem_ctl),
        .dividend (mag_reg),
        .divisor  (div_reg),
        .sts      (rem_sts)
    );

    // Trial divisors stay odd while the search runs.
    a_div_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOP || state_reg == ST_WAIT) |-> div_reg[0])
        else $error("even trial divisor");

    // The remainder unit only works while the sequencer waits for it.
    a_rem_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        (rem_sts.busy || rem_sts.done) |-> state_reg == ST_WAIT)
        else $error("remainder unit active outside the wait state");

    // An accepted transfer closes the input until its result is issued.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened right after a transfer");

endmodule
